### rtl/ssm_pkg.sv
package ssm_pkg;

    // Number of merged streams; the source id field is three bits wide.
    localparam int SOURCES  = 8;
    localparam int SID_W    = 3;
    localparam int KEY_W    = 63;
    localparam int CNT_W    = 48;
    localparam int MASK_W   = 8;
    localparam int INT_BITS = 32;

    // Scan index and the width of an unclipped sum of all heads.
    localparam int IDX_W = (SOURCES > 1) ? $clog2(SOURCES) : 1;
    localparam int SUM_W = CNT_W + IDX_W;

    // Command queue between the front and the back.
    localparam int Q_DEPTH = 2;
    localparam int Q_PTR_W = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
    localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

    typedef logic [SID_W-1:0]   sid_t;
    typedef logic [KEY_W-1:0]   key_t;
    typedef logic [CNT_W-1:0]   cnt_t;
    typedef logic [MASK_W-1:0]  mask_t;
    typedef logic [SUM_W-1:0]   sum_t;
    typedef logic [IDX_W-1:0]   idx_t;
    typedef logic [SOURCES-1:0] src_vec_t;

    typedef struct packed {
        logic is_end;
        sid_t sid;
        key_t key;
        cnt_t cnt;
    } q_entry_t;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_SCAN,
        BK_EMIT
    } bk_state_t;

endpackage

### rtl/ssm_rec_if.sv
interface ssm_rec_if;
    import ssm_pkg::*;

    logic valid;
    logic ready;
    sid_t source_id;
    key_t record_key;
    cnt_t record_count;
    logic stream_ended;

    modport source (
        output valid, source_id, record_key, record_count, stream_ended,
        input  ready
    );

    modport sink (
        input  valid, source_id, record_key, record_count, stream_ended,
        output ready
    );

endinterface

### rtl/ssm_res_if.sv
interface ssm_res_if;
    import ssm_pkg::*;

    logic  valid;
    logic  ready;
    key_t  merged_key;
    cnt_t  merged_count;
    mask_t refill_mask;
    logic  count_saturated;
    logic  all_done;

    modport source (
        output valid, merged_key, merged_count, refill_mask, count_saturated, all_done,
        input  ready
    );

    modport sink (
        input  valid, merged_key, merged_count, refill_mask, count_saturated, all_done,
        output ready
    );

endinterface

### rtl/sorted_stream_merge_count_sum.sv
// Sorted stream merge with count aggregation. Items on rec_in carry either the
// next (key, count) record of one source or that source's end mark; each
// source's records must arrive in ascending key order. The block holds one
// head per source. Once every source that has not ended holds a head, it
// emits on res_out the smallest key, the sum of the counts of all heads with
// that key (clipped at 2^32-1 in integer mode, 2^48-1 in fixed-point mode,
// with count_saturated flagging the clip) and refill_mask naming the heads
// consumed; feed those sources next. An item that leaves some live source
// without a head gives no result. After every source has ended, each item
// gives one result with all_done set and all other fields zero. Items with a
// source id at or above the source count are dropped at the input. The input
// side takes one item a cycle into a two-entry queue while it is not full.
// The back end scans for a result one head a cycle, then emits it once the
// output register is free; a final result skips the scan, and an item that
// gives no result only updates the heads. Results sit in an output register,
// so a stalled res_out does not stop the input queue from filling.
// Write fractional_mode through cfg_we/cfg_data only while the block is idle.
module sorted_stream_merge_count_sum (
    input  logic      clk,
    input  logic      rst_n,
    ssm_rec_if.sink   rec_in,
    ssm_res_if.source res_out,
    input  logic      cfg_we,
    input  logic      cfg_data
);
    import ssm_pkg::*;

    logic     fractional_mode_reg;

    logic     push;
    q_entry_t push_data;
    logic     pop;
    logic     q_valid;
    logic     q_full;
    q_entry_t q_head;

    // Hold the count mode; it applies to every result formed after the write.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fractional_mode_reg <= 1'b0;
        end
        else if (cfg_we)
        begin
            fractional_mode_reg <= cfg_data;
        end
    end

    // Classify incoming items and drop those for absent sources.
    ssm_front u_front (
        .rec_in    (rec_in),
        .q_full    (q_full),
        .push      (push),
        .push_data (push_data)
    );

    // Decouple intake from the head scan.
    ssm_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .pop       (pop),
        .q_valid   (q_valid),
        .q_full    (q_full),
        .q_head    (q_head)
    );

    // Update heads, scan for the minimum, sum, clip and emit.
    ssm_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .frac_mode (fractional_mode_reg),
        .q_valid   (q_valid),
        .q_head    (q_head),
        .pop       (pop),
        .res_out   (res_out)
    );

endmodule

### rtl/ssm_front.sv
module ssm_front (
    ssm_rec_if.sink           rec_in,
    input  logic              q_full,
    output logic              push,
    output ssm_pkg::q_entry_t push_data
);
    import ssm_pkg::*;

    logic in_range;

    // Drop items for sources beyond the configured count.
    assign in_range = (int'(rec_in.source_id) < SOURCES);

    assign rec_in.ready = !q_full;
    assign push         = rec_in.valid && !q_full && in_range;

    assign push_data.is_end = rec_in.stream_ended;
    assign push_data.sid    = rec_in.source_id;
    assign push_data.key    = rec_in.record_key;
    assign push_data.cnt    = rec_in.record_count;

endmodule

### rtl/ssm_queue.sv
module ssm_queue (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  ssm_pkg::q_entry_t push_data,
    input  logic              pop,
    output logic              q_valid,
    output logic              q_full,
    output ssm_pkg::q_entry_t q_head
);
    import ssm_pkg::*;

    q_entry_t             mem_reg [Q_DEPTH];
    logic [Q_PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [Q_PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [Q_CNT_W-1:0]   count_reg, count_next;

    assign q_valid = (count_reg != '0);
    assign q_full  = (count_reg == Q_CNT_W'(Q_DEPTH));
    assign q_head  = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == Q_PTR_W'(Q_DEPTH - 1)) ? '0
                                                                : wr_ptr_reg + Q_PTR_W'(1);
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == Q_PTR_W'(Q_DEPTH - 1)) ? '0
                                                                : rd_ptr_reg + Q_PTR_W'(1);
        end
        unique case ({push, pop})
            2'b10:   count_next = count_reg + Q_CNT_W'(1);
            2'b01:   count_next = count_reg - Q_CNT_W'(1);
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

### rtl/ssm_back.sv
module ssm_back (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              frac_mode,
    input  logic              q_valid,
    input  ssm_pkg::q_entry_t q_head,
    output logic              pop,
    ssm_res_if.source         res_out
);
    import ssm_pkg::*;

    bk_state_t state_reg, state_next;

    key_t     head_key_reg [SOURCES];
    cnt_t     head_cnt_reg [SOURCES];
    src_vec_t hv_reg;
    src_vec_t fin_reg;

    idx_t     idx_reg;
    logic     have_reg;
    key_t     min_reg;
    sum_t     sum_reg;
    src_vec_t mask_reg;
    logic     final_reg;

    logic     out_valid_reg;
    key_t     out_key_reg;
    cnt_t     out_cnt_reg;
    mask_t    out_mask_reg;
    logic     out_sat_reg;
    logic     out_done_reg;

    src_vec_t sel;
    src_vec_t fin_upd;
    src_vec_t hv_upd;
    logic     all_fin;
    logic     all_heads;
    logic     out_free;
    logic     scan_last;

    key_t     cur_key;
    cnt_t     cur_cnt;
    logic     cur_live;
    src_vec_t cur_bit;
    logic     take_new;
    logic     take_eq;

    sum_t     limit;
    logic     sat;

    // Head state as it stands once the item at the queue head is applied.
    always_comb
    begin
        sel     = src_vec_t'(1) << q_head.sid;
        fin_upd = fin_reg | (q_head.is_end ? sel : '0);
        if (q_head.is_end)
        begin
            hv_upd = hv_reg & ~sel;
        end
        else if ((fin_reg & sel) != '0)
        begin
            hv_upd = hv_reg;
        end
        else
        begin
            hv_upd = hv_reg | sel;
        end
        all_fin   = &fin_upd;
        all_heads = &(hv_upd | fin_upd);
    end

    assign out_free  = !out_valid_reg || res_out.ready;
    assign scan_last = (idx_reg == IDX_W'(SOURCES - 1));

    // One head per scan cycle: track the minimum key and sum its counts.
    always_comb
    begin
        cur_key  = head_key_reg[idx_reg];
        cur_cnt  = head_cnt_reg[idx_reg];
        cur_live = !fin_reg[idx_reg];
        cur_bit  = src_vec_t'(1) << idx_reg;
        take_new = cur_live && (!have_reg || (cur_key < min_reg));
        take_eq  = cur_live && have_reg && (cur_key == min_reg);
    end

    always_comb
    begin
        limit = frac_mode ? sum_t'({CNT_W{1'b1}}) : sum_t'({INT_BITS{1'b1}});
        sat   = (sum_reg > limit);
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            BK_IDLE:
            begin
                if (q_valid)
                begin
                    if (all_fin)
                    begin
                        state_next = BK_EMIT;
                    end
                    else if (all_heads)
                    begin
                        state_next = BK_SCAN;
                    end
                end
            end
            BK_SCAN:
            begin
                if (scan_last)
                begin
                    state_next = BK_EMIT;
                end
            end
            BK_EMIT:
            begin
                if (out_free)
                begin
                    state_next = BK_IDLE;
                end
            end
            default: state_next = BK_IDLE;
        endcase
    end

    always_comb
    begin
        pop = (state_reg == BK_IDLE) && q_valid;
    end

    // Head storage holds only what records wrote.
    always_ff @(posedge clk)
    begin
        if (pop && !q_head.is_end && !fin_reg[q_head.sid])
        begin
            head_key_reg[q_head.sid] <= q_head.key;
            head_cnt_reg[q_head.sid] <= q_head.cnt;
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == BK_SCAN)
        begin
            if (take_new)
            begin
                min_reg  <= cur_key;
                sum_reg  <= sum_t'(cur_cnt);
                mask_reg <= cur_bit;
            end
            else if (take_eq)
            begin
                sum_reg  <= sum_reg + sum_t'(cur_cnt);
                mask_reg <= mask_reg | cur_bit;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= BK_IDLE;
            hv_reg    <= '0;
            fin_reg   <= '0;
            idx_reg   <= '0;
            have_reg  <= 1'b0;
            final_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (pop)
            begin
                hv_reg    <= hv_upd;
                fin_reg   <= fin_upd;
                final_reg <= all_fin;
                idx_reg   <= '0;
                have_reg  <= 1'b0;
            end
            else if (state_reg == BK_SCAN)
            begin
                idx_reg <= idx_reg + IDX_W'(1);
                if (take_new)
                begin
                    have_reg <= 1'b1;
                end
            end
            else if ((state_reg == BK_EMIT) && out_free && !final_reg)
            begin
                // Drop the consumed heads.
                hv_reg <= hv_reg & ~mask_reg;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if ((state_reg == BK_EMIT) && out_free)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (res_out.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if ((state_reg == BK_EMIT) && out_free)
        begin
            if (final_reg)
            begin
                out_key_reg  <= '0;
                out_cnt_reg  <= '0;
                out_mask_reg <= '0;
                out_sat_reg  <= 1'b0;
                out_done_reg <= 1'b1;
            end
            else
            begin
                out_key_reg  <= min_reg;
                out_cnt_reg  <= sat ? limit[CNT_W-1:0] : sum_reg[CNT_W-1:0];
                out_mask_reg <= mask_t'(mask_reg);
                out_sat_reg  <= sat;
                out_done_reg <= 1'b0;
            end
        end
    end

    assign res_out.valid           = out_valid_reg;
    assign res_out.merged_key      = out_key_reg;
    assign res_out.merged_count    = out_cnt_reg;
    assign res_out.refill_mask     = out_mask_reg;
    assign res_out.count_saturated = out_sat_reg;
    assign res_out.all_done        = out_done_reg;

    a_head_not_finished: assert property (@(posedge clk) disable iff (!rst_n)
        (hv_reg & fin_reg) == '0)
        else $error("head held for a finished source");

    a_scan_heads_full: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == BK_SCAN) |-> (&(hv_reg | fin_reg)))
        else $error("scan started while a live source lacks a head");

    a_emit_mask: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == BK_EMIT) && !final_reg)
            |-> ((mask_reg != '0) && ((mask_reg & ~hv_reg) == '0)))
        else $error("refill mask empty or names a source without a head");

    a_final_clean: assert property (@(posedge clk) disable iff (!rst_n)
        (res_out.valid && res_out.all_done)
            |-> ((res_out.refill_mask == '0) && (res_out.merged_count == '0)))
        else $error("final result carries a mask or a count");

endmodule

### tb/tb_sorted_stream_merge_count_sum.sv
`timescale 1ns / 100ps

module tb_sorted_stream_merge_count_sum;
    import ssm_pkg::*;

    // Clock, reset and run-length constants
    localparam int HALF_PERIOD_NS  = 1;
    localparam int RESET_CYCLES    = 9;
    // Drain margin: two queued items plus the scan of one result.
    localparam int DRAIN_CYCLES    = 40;
    // Abort when this many cycles pass with no item moving on either side.
    localparam int WATCHDOG_CYCLES = 2000;
    localparam int REPORT_LIMIT    = 10;

    localparam key_t KEY_TOP = '1;
    localparam cnt_t CNT_TOP = '1;

    // One merged result as the block should emit it
    typedef struct packed {
        key_t  key;
        cnt_t  count;
        mask_t refill;
        logic  clipped;
        logic  done;
    } merge_out_t;

    logic clk = 1'b0;
    logic rst_n;
    logic cfg_we;
    logic cfg_data;

    ssm_rec_if rec_ch ();
    ssm_res_if res_ch ();

    sorted_stream_merge_count_sum i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .rec_in   (rec_ch),
        .res_out  (res_ch),
        .cfg_we   (cfg_we),
        .cfg_data (cfg_data)
    );

    always #(HALF_PERIOD_NS) clk = ~clk;

    // Shadow copy of the merge state, updated as each item is accepted
    key_t head_key  [SOURCES];
    cnt_t head_cnt  [SOURCES];
    bit   head_held [SOURCES];
    bit   src_ended [SOURCES];
    bit   frac_mode;

    // Results predicted but not yet seen on res_ch, oldest first
    merge_out_t pending_merges [$];

    // Last key handed to each source; records climb from here
    key_t key_trail [SOURCES];

    int   items_sent;
    int   results_seen;
    int   mismatch_count;
    int   phase_no;
    bit   steady_flow;

    // Handshakes seen at the falling edge complete at the next rising edge
    bit         rec_seen;
    bit         res_seen;
    merge_out_t res_snap;

    // Apply one accepted item to the shadow state and queue any result it causes.
    function automatic void merge_predict(input sid_t sid, input key_t key,
                                          input cnt_t count, input logic ended);
        bit          finished_all;
        bit          found;
        key_t        low_key;
        logic [63:0] total;
        logic [63:0] ceiling;
        merge_out_t  res;
        finished_all = 1'b1;
        found        = 1'b0;
        low_key      = '0;
        total        = '0;
        res          = '0;
        // Drop ids past the last source.
        if (int'(sid) >= SOURCES)
            return;
        // An end mark retires the source and drops its head; a record for a
        // retired source is ignored, otherwise it fills or replaces the head.
        if (ended)
        begin
            src_ended[sid] = 1'b1;
            head_held[sid] = 1'b0;
        end
        else if (!src_ended[sid])
        begin
            head_key[sid]  = key;
            head_cnt[sid]  = count;
            head_held[sid] = 1'b1;
        end
        for (int s = 0; s < SOURCES; s++)
        begin
            if (!src_ended[s])
            begin
                finished_all = 1'b0;
                // Hold off: a live source still waits for its record.
                if (!head_held[s])
                    return;
                if (!found || head_key[s] < low_key)
                begin
                    low_key = head_key[s];
                    found   = 1'b1;
                end
            end
        end
        if (finished_all)
        begin
            res.done = 1'b1;
            pending_merges.push_back(res);
            return;
        end
        // Consume every head sharing the smallest key in one result.
        for (int s = 0; s < SOURCES; s++)
        begin
            if (head_held[s] && !src_ended[s] && head_key[s] == low_key)
            begin
                total         += 64'(head_cnt[s]);
                res.refill[s]  = 1'b1;
                head_held[s]   = 1'b0;
            end
        end
        // Clip at the limit of the mode in force now, not when counts arrived.
        ceiling = frac_mode ? 64'hFFFF_FFFF_FFFF : 64'hFFFF_FFFF;
        if (total > ceiling)
        begin
            total       = ceiling;
            res.clipped = 1'b1;
        end
        res.key   = low_key;
        res.count = total[CNT_W-1:0];
        pending_merges.push_back(res);
    endfunction

    // Compare one accepted result against the oldest prediction.
    function automatic void check_result(input merge_out_t got);
        merge_out_t want;
        if (pending_merges.size() == 0)
        begin
            mismatch_count++;
            if (mismatch_count <= REPORT_LIMIT)
                $display("unexpected result: key=%h count=%h refill=%h clipped=%b done=%b",
                         got.key, got.count, got.refill, got.clipped, got.done);
            return;
        end
        want = pending_merges.pop_front();
        if (got.key !== want.key || got.count !== want.count || got.refill !== want.refill
            || got.clipped !== want.clipped || got.done !== want.done)
        begin
            mismatch_count++;
            if (mismatch_count <= REPORT_LIMIT)
            begin
                $display("result %0d: expected key=%h count=%h refill=%h clipped=%b done=%b",
                         results_seen, want.key, want.count, want.refill, want.clipped,
                         want.done);
                $display("result %0d: actual   key=%h count=%h refill=%h clipped=%b done=%b",
                         results_seen, got.key, got.count, got.refill, got.clipped, got.done);
            end
        end
        results_seen++;
    endfunction

    // Mostly no gap, often a short one, now and then a long one.
    function automatic int pick_gap();
        int pick;
        pick = $urandom_range(0, 99);
        if (steady_flow || pick < 55)
            return 0;
        if (pick < 90)
            return $urandom_range(1, 3);
        if (pick < 98)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // Counts: mostly small, some that clip in integer mode, some full width.
    function automatic cnt_t pick_count();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 55)
            return cnt_t'($urandom_range(0, 1000));
        if (pick < 75)
            return cnt_t'($urandom);
        if (pick < 87)
            return {16'h0000, 1'b1, 31'($urandom)};
        return {16'($urandom), 32'($urandom)};
    endfunction

    function automatic key_t rand_key();
        return {31'($urandom), 32'($urandom)};
    endfunction

    // Advance a source's key in small steps so that heads often collide.
    function automatic key_t next_key(input int s);
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 75)
            key_trail[s] += key_t'($urandom_range(0, 2));
        else if (pick < 98)
            key_trail[s] += key_t'($urandom_range(3, 40));
        else
            key_trail[s] += {23'b0, 8'($urandom), 32'($urandom)};
        return key_trail[s];
    endfunction

    // Drive one item, wait for it to be taken, then predict its effect.
    // Entered and left on a rising edge; valid stays high for a following item.
    task automatic send_record(input sid_t sid, input key_t key, input cnt_t count,
                               input logic ended);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            rec_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        rec_ch.source_id    <= sid;
        rec_ch.record_key   <= key;
        rec_ch.record_count <= count;
        rec_ch.stream_ended <= ended;
        rec_ch.valid        <= 1'b1;
        @(negedge clk);
        while (rec_ch.ready !== 1'b1)
            @(negedge clk);
        @(posedge clk);
        merge_predict(sid, key, count, ended);
        items_sent++;
    endtask

    // Drop valid and wait until the block has nothing left in flight.
    task automatic go_idle();
        rec_ch.valid <= 1'b0;
        while (pending_merges.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_mode(input bit mode);
        go_idle();
        cfg_we   <= 1'b1;
        cfg_data <= mode;
        @(posedge clk);
        cfg_we    <= 1'b0;
        frac_mode  = mode;
    endtask

    // Feed every live source that lacks a head, in random order.
    task automatic refill_round();
        int waiting [$];
        int j;
        int tmp;
        for (int s = 0; s < SOURCES; s++)
            if (!src_ended[s] && !head_held[s])
                waiting.push_back(s);
        for (int i = waiting.size() - 1; i > 0; i--)
        begin
            j          = $urandom_range(0, i);
            tmp        = waiting[i];
            waiting[i] = waiting[j];
            waiting[j] = tmp;
        end
        foreach (waiting[i])
            send_record(sid_t'(waiting[i]), next_key(waiting[i]), pick_count(), 1'b0);
    endtask

    // Noise: overwrite the head of a random source out of turn.
    task automatic replace_head();
        int s;
        s = $urandom_range(0, SOURCES - 1);
        if (!src_ended[s])
            send_record(sid_t'(s), next_key(s), pick_count(), 1'b0);
    endtask

    // Integer mode: key extremes, a replaced head, two heads tied at key zero
    // with a single count past the integer limit, then all eight tied at the
    // largest key.
    task automatic test_extremes();
        send_record(sid_t'(2), key_t'(5), cnt_t'(7), 1'b0);
        send_record(sid_t'(2), KEY_TOP, CNT_TOP, 1'b0);
        send_record(sid_t'(0), '0, CNT_TOP, 1'b0);
        send_record(sid_t'(1), '0, '0, 1'b0);
        for (int s = 3; s < SOURCES; s++)
            send_record(sid_t'(s), KEY_TOP, cnt_t'(s), 1'b0);
        send_record(sid_t'(1), KEY_TOP, cnt_t'(5), 1'b0);
        send_record(sid_t'(0), KEY_TOP, '0, 1'b0);
    endtask

    // Fixed-point mode: all heads tied, the sum runs past 48 bits.
    task automatic test_fixed_point_clip();
        key_t tie_key;
        tie_key = rand_key();
        write_mode(1'b1);
        for (int s = SOURCES - 1; s >= 0; s--)
            send_record(sid_t'(s), tie_key,
                        (s == 0) ? CNT_TOP : (s == 1) ? cnt_t'(1) : cnt_t'($urandom_range(0, 65535)),
                        1'b0);
    endtask

    // Load counts in fixed-point mode, switch to integer mode, then complete
    // the set: the clip follows the mode at the time the result forms.
    task automatic test_mode_switch();
        key_t tie_key;
        tie_key = rand_key();
        for (int s = 0; s < SOURCES - 1; s++)
            send_record(sid_t'(s), tie_key, (s == 0) ? cnt_t'(48'h1_0000_0000) : '0, 1'b0);
        write_mode(1'b0);
        send_record(sid_t'(SOURCES - 1), tie_key, '0, 1'b0);
    endtask

    // Well-formed refill rounds with random content, salted with replaced heads.
    task automatic test_random_merge(input bit mode, input int budget, input bit steady);
        int   target;
        key_t base;
        write_mode(mode);
        phase_no++;
        // Start each phase above the keys of the random phases before it.
        base = (key_t'(phase_no) << 60) | {23'b0, 8'($urandom), 32'($urandom)};
        for (int s = 0; s < SOURCES; s++)
            key_trail[s] = base;
        steady_flow = steady;
        target      = items_sent + budget;
        while (items_sent < target)
        begin
            if ($urandom_range(0, 99) < 85)
                refill_round();
            else
                replace_head();
        end
        steady_flow = 1'b0;
    endtask

    // Retire the sources one by one while merging continues, poke retired
    // sources, then repeat the final result with a second end mark and a
    // record after everything has ended.
    task automatic test_stream_end();
        int order [SOURCES];
        int j;
        int tmp;
        write_mode(1'($urandom_range(0, 1)));
        for (int s = 0; s < SOURCES; s++)
            order[s] = s;
        for (int i = SOURCES - 1; i > 0; i--)
        begin
            j        = $urandom_range(0, i);
            tmp      = order[i];
            order[i] = order[j];
            order[j] = tmp;
        end
        for (int k = 0; k < SOURCES; k++)
        begin
            repeat ($urandom_range(2, 6)) refill_round();
            if (k > 0 && $urandom_range(0, 1) == 1)
                send_record(sid_t'(order[$urandom_range(0, k - 1)]), rand_key(), pick_count(),
                            1'b0);
            send_record(sid_t'(order[k]), rand_key(), pick_count(), 1'b1);
        end
        send_record(sid_t'($urandom_range(0, SOURCES - 1)), rand_key(), pick_count(), 1'b1);
        send_record(sid_t'($urandom_range(0, SOURCES - 1)), rand_key(), pick_count(), 1'b0);
    endtask

    // Sample both handshakes at the falling edge ahead of the rising edge that completes them.
    always @(negedge clk)
    begin
        rec_seen = (rst_n === 1'b1) && (rec_ch.valid === 1'b1) && (rec_ch.ready === 1'b1);
        res_seen = (rst_n === 1'b1) && (res_ch.valid === 1'b1) && (res_ch.ready === 1'b1);
        res_snap.key     = res_ch.merged_key;
        res_snap.count   = res_ch.merged_count;
        res_snap.refill  = res_ch.refill_mask;
        res_snap.clipped = res_ch.count_saturated;
        res_snap.done    = res_ch.all_done;
    end

    // Result side: check each taken result, stall ready at random.
    initial
    begin : result_sink
        int hold;
        hold = 0;
        res_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (res_seen)
                check_result(res_snap);
            if (hold > 0)
            begin
                res_ch.ready <= 1'b0;
                hold--;
            end
            else
            begin
                res_ch.ready <= 1'b1;
                if ($urandom_range(0, 99) < 30)
                    hold = pick_gap();
            end
        end
    end

    // End the run if nothing moves on either side for too long.
    initial
    begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < WATCHDOG_CYCLES)
        begin
            @(posedge clk);
            if (rec_seen || res_seen)
                quiet = 0;
            else
                quiet++;
        end
        $display("sorted_stream_merge_count_sum: mismatch");
        $finish;
    end

    initial
    begin : stimulus
        rst_n               <= 1'b0;
        cfg_we              <= 1'b0;
        cfg_data            <= 1'b0;
        rec_ch.valid        <= 1'b0;
        rec_ch.source_id    <= '0;
        rec_ch.record_key   <= '0;
        rec_ch.record_count <= '0;
        rec_ch.stream_ended <= 1'b0;
        frac_mode      = 1'b0;
        items_sent     = 0;
        results_seen   = 0;
        mismatch_count = 0;
        phase_no       = 0;
        steady_flow    = 1'b0;
        for (int s = 0; s < SOURCES; s++)
        begin
            head_held[s] = 1'b0;
            src_ended[s] = 1'b0;
            key_trail[s] = '0;
        end
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_extremes();
        test_fixed_point_clip();
        test_mode_switch();
        // Alternate the mode; every other phase runs with no idling at all.
        test_random_merge(1'b1, 150, 1'b0);
        test_random_merge(1'b0, 150, 1'b1);
        test_random_merge(1'b1, 150, 1'b0);
        test_random_merge(1'b0, 150, 1'b1);
        test_stream_end();

        go_idle();
        if (mismatch_count == 0)
            $display("sorted_stream_merge_count_sum: match");
        else
            $display("sorted_stream_merge_count_sum: mismatch");
        $finish;
    end

endmodule

### sorted_stream_merge_count_sum.f
rtl/ssm_pkg.sv
rtl/ssm_rec_if.sv
rtl/ssm_res_if.sv
rtl/ssm_front.sv
rtl/ssm_queue.sv
rtl/ssm_back.sv
rtl/sorted_stream_merge_count_sum.sv
tb/tb_sorted_stream_merge_count_sum.sv
